// ===== design/accumulator_load_jsr_cpu_step_unit_defines.svh =====
// Assertion macros shared by the checker of the CPU step unit.
`ifndef ACCUMULATOR_LOAD_JSR_CPU_STEP_UNIT_DEFINES_SVH
`define ACCUMULATOR_LOAD_JSR_CPU_STEP_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ALJCPU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ALJCPU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/aljcpu_pkg.sv =====
// Types, constants and decode functions of the CPU step unit.
`default_nettype none

package aljcpu_pkg;

  localparam int unsigned MEM_DEPTH = 65536;
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);

  localparam logic [15:0] START_PC_RST = 16'hFFFC;
  localparam logic [7:0]  STACK_PAGE   = 8'h01;

  localparam logic [7:0] OP_LDA_IMM  = 8'hA9;
  localparam logic [7:0] OP_LDA_ZP   = 8'hA5;
  localparam logic [7:0] OP_LDA_ZPX  = 8'hB5;
  localparam logic [7:0] OP_LDA_ABS  = 8'hAD;
  localparam logic [7:0] OP_LDA_ABSX = 8'hBD;
  localparam logic [7:0] OP_LDA_ABSY = 8'hB9;
  localparam logic [7:0] OP_LDA_INDX = 8'hA1;
  localparam logic [7:0] OP_LDA_INDY = 8'hB1;
  localparam logic [7:0] OP_JSR      = 8'h20;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_EXEC    = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    CFG_START_PC = 2'd0,
    CFG_START_SP = 2'd1,
    CFG_INDEX_X  = 2'd2,
    CFG_INDEX_Y  = 2'd3
  } cfg_index_e;

  typedef enum logic [3:0] {
    OPK_IMM,
    OPK_ZP,
    OPK_ZPX,
    OPK_ABS,
    OPK_ABSX,
    OPK_ABSY,
    OPK_INDX,
    OPK_INDY,
    OPK_JSR,
    OPK_ILL
  } op_kind_e;

  // Memory access issued by the datapath in a cycle.
  typedef enum logic [3:0] {
    MEM_NONE,
    MEM_CLEAR,
    MEM_REQ_WR,
    MEM_REQ_RD,
    MEM_FETCH,
    MEM_ZP,
    MEM_ZP_X,
    MEM_ZP_NEXT,
    MEM_ABS,
    MEM_ABS_X,
    MEM_ABS_Y,
    MEM_PUSH_HI,
    MEM_PUSH_LO
  } mem_op_e;

  typedef struct packed {
    logic     accept;
    logic     restart;
    logic     set_op;
    op_kind_e kind;
    logic     lo_load;
    logic     load_acc;
    logic     read_capture;
    logic     finish;
    mem_op_e  mem_op;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       clr_done;
    logic       out_free;
  } dp_status_t;

  // Input item, last field in the low bits.
  typedef struct packed {
    logic [7:0]  mem_wdata;
    logic [15:0] mem_addr;
  } in_item_t;

  // Result item, last field in the low bits.
  typedef struct packed {
    logic [1:0]  pad;
    logic        illegal_opcode;
    logic [2:0]  cycles_used;
    logic        negative_flag;
    logic        zero_flag;
    logic [7:0]  sp_out;
    logic [15:0] pc_out;
    logic [7:0]  acc_out;
    logic [7:0]  read_data;
  } out_item_t;

  function automatic op_kind_e op_kind_f(logic [7:0] op);
    op_kind_e k;
    case (op)
      OP_LDA_IMM:  k = OPK_IMM;
      OP_LDA_ZP:   k = OPK_ZP;
      OP_LDA_ZPX:  k = OPK_ZPX;
      OP_LDA_ABS:  k = OPK_ABS;
      OP_LDA_ABSX: k = OPK_ABSX;
      OP_LDA_ABSY: k = OPK_ABSY;
      OP_LDA_INDX: k = OPK_INDX;
      OP_LDA_INDY: k = OPK_INDY;
      OP_JSR:      k = OPK_JSR;
      default:     k = OPK_ILL;
    endcase
    return k;
  endfunction

  // Base cycle count; page-cross penalty is added separately.
  function automatic logic [2:0] op_cycles_f(op_kind_e kind);
    logic [2:0] c;
    case (kind)
      OPK_IMM:  c = 3'd2;
      OPK_ZP:   c = 3'd3;
      OPK_ZPX:  c = 3'd4;
      OPK_ABS:  c = 3'd4;
      OPK_ABSX: c = 3'd4;
      OPK_ABSY: c = 3'd4;
      OPK_INDX: c = 3'd6;
      OPK_INDY: c = 3'd5;
      OPK_JSR:  c = 3'd6;
      default:  c = 3'd1;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/accumulator_load_jsr_cpu_step_unit.sv =====
// Top level of the CPU step unit: controller, datapath and port wiring.
`default_nettype none

// Executes one request per input item (write byte, read byte, restart, or one
// LDA/JSR instruction) against a private 64 KiB memory and returns one result
// item with the register file. After reset the memory is zeroed by a clearing
// pass, one byte per cycle, during which no item is accepted; configuration
// writes are taken at any time. Every step is paced by the single-port memory,
// one access per cycle, and an item is accepted only once the previous one has
// run through all its steps. A finished result waits in an output register, so
// the next item is accepted while the previous result is still held.

module accumulator_load_jsr_cpu_step_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [1:0]                          cfg_index_i,
  input  wire logic [15:0]                         cfg_data_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [15:0] mem_addr, [23:16] mem_wdata
  input  wire logic [aljcpu_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] req_type
  input  wire logic [1:0]                          s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [7:0] read_data, [15:8] acc_out, [31:16] pc_out, [39:32] sp_out,
  // [40] zero_flag, [41] negative_flag, [44:42] cycles_used,
  // [45] illegal_opcode, [47:46] zero
  output logic      [aljcpu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import aljcpu_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  aljcpu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tuser_i  (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  aljcpu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_axis_tdata),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

`default_nettype wire

// ===== design/aljcpu_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none

module aljcpu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/aljcpu_datapath.sv =====
// Datapath: register file, config registers, address generation, memory and result register.
`default_nettype none

module aljcpu_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  input  wire logic [1:0]                          cfg_index_i,
  input  wire logic [15:0]                         cfg_data_i,
  input  wire logic [aljcpu_pkg::IN_TDATA_W-1:0]   s_tdata_i,
  input  wire logic                                m_tready_i,
  output logic                                     m_tvalid_o,
  output logic      [aljcpu_pkg::OUT_TDATA_W-1:0]  m_tdata_o,
  input  wire aljcpu_pkg::dp_cmd_t                 cmd_i,
  output aljcpu_pkg::dp_status_t                   status_o
);
  import aljcpu_pkg::*;

  logic [15:0] pc_q;
  logic [7:0]  sp_q, acc_q;
  logic        z_q, n_q;
  logic [15:0] start_pc_q;
  logic [7:0]  start_sp_q, x_q, y_q;
  logic [MEM_AW-1:0] clr_q;
  logic        out_valid_q;

  logic [15:0] req_addr_q;
  logic [7:0]  req_wdata_q;
  logic [7:0]  zp_q, lo_q, hi_q, rd_res_q;
  logic        cross_q, ill_q;
  logic [2:0]  cyc_q;
  out_item_t   out_q, out_d;

  logic              ram_we;
  logic [MEM_AW-1:0] ram_addr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic [7:0]        zp_sum, idx;
  logic [15:0]       ea_base, ea_idx, pc_m1;
  in_item_t          in_w;

  assign in_w    = in_item_t'(s_tdata_i);
  assign zp_sum  = ram_rdata + ((cmd_i.mem_op == MEM_ZP_X) ? x_q : 8'h00);
  assign idx     = (cmd_i.mem_op == MEM_ABS_Y) ? y_q : x_q;
  assign ea_base = {ram_rdata, lo_q};
  assign ea_idx  = ea_base + {8'h00, idx};
  assign pc_m1   = pc_q - 16'd1;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 8'h00;
    ram_addr  = '0;
    case (cmd_i.mem_op)
      MEM_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
      end
      MEM_REQ_WR: begin
        ram_we    = 1'b1;
        ram_addr  = req_addr_q;
        ram_wdata = req_wdata_q;
      end
      MEM_REQ_RD:  ram_addr = req_addr_q;
      MEM_FETCH:   ram_addr = pc_q;
      MEM_ZP:      ram_addr = {8'h00, zp_sum};
      MEM_ZP_X:    ram_addr = {8'h00, zp_sum};
      MEM_ZP_NEXT: ram_addr = {8'h00, zp_q + 8'd1};
      MEM_ABS:     ram_addr = ea_base;
      MEM_ABS_X:   ram_addr = ea_idx;
      MEM_ABS_Y:   ram_addr = ea_idx;
      MEM_PUSH_HI: begin
        ram_we    = 1'b1;
        ram_addr  = {STACK_PAGE, sp_q};
        ram_wdata = pc_m1[15:8];
      end
      MEM_PUSH_LO: begin
        ram_we    = 1'b1;
        ram_addr  = {STACK_PAGE, sp_q};
        ram_wdata = pc_m1[7:0];
      end
      default: ram_addr = '0;
    endcase
  end

  aljcpu_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    out_d.pad            = 2'b00;
    out_d.illegal_opcode = ill_q;
    out_d.cycles_used    = cyc_q + {2'b00, cross_q};
    out_d.negative_flag  = n_q;
    out_d.zero_flag      = z_q;
    out_d.sp_out         = sp_q;
    out_d.pc_out         = pc_q;
    out_d.acc_out        = acc_q;
    out_d.read_data      = rd_res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= START_PC_RST;
      sp_q        <= 8'h00;
      acc_q       <= 8'h00;
      z_q         <= 1'b0;
      n_q         <= 1'b0;
      start_pc_q  <= START_PC_RST;
      start_sp_q  <= 8'h00;
      x_q         <= 8'h00;
      y_q         <= 8'h00;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_START_PC: start_pc_q <= cfg_data_i;
          CFG_START_SP: start_sp_q <= cfg_data_i[7:0];
          CFG_INDEX_X:  x_q        <= cfg_data_i[7:0];
          CFG_INDEX_Y:  y_q        <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.mem_op == MEM_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.restart) begin
        pc_q  <= start_pc_q;
        sp_q  <= start_sp_q;
        acc_q <= 8'h00;
        z_q   <= 1'b0;
        n_q   <= 1'b0;
      end
      if (cmd_i.mem_op == MEM_FETCH) begin
        pc_q <= pc_q + 16'd1;
      end
      if (cmd_i.mem_op == MEM_PUSH_HI || cmd_i.mem_op == MEM_PUSH_LO) begin
        sp_q <= sp_q - 8'd1;
      end
      if (cmd_i.mem_op == MEM_PUSH_LO) begin
        pc_q <= {hi_q, lo_q};
      end
      if (cmd_i.load_acc) begin
        acc_q <= ram_rdata;
        z_q   <= (ram_rdata == 8'h00);
        n_q   <= ram_rdata[7];
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and per-instruction scratch; all cleared or written before use.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_addr_q  <= in_w.mem_addr;
      req_wdata_q <= in_w.mem_wdata;
      cross_q     <= 1'b0;
      cyc_q       <= 3'd0;
      ill_q       <= 1'b0;
      rd_res_q    <= 8'h00;
    end
    if (cmd_i.set_op) begin
      cyc_q <= op_cycles_f(cmd_i.kind);
      ill_q <= (cmd_i.kind == OPK_ILL);
    end
    if (cmd_i.mem_op == MEM_ZP || cmd_i.mem_op == MEM_ZP_X) begin
      zp_q <= zp_sum;
    end
    if (cmd_i.lo_load) begin
      lo_q <= ram_rdata;
    end
    if (cmd_i.mem_op == MEM_PUSH_HI) begin
      hi_q <= ram_rdata;
    end
    if (cmd_i.mem_op == MEM_ABS_X || cmd_i.mem_op == MEM_ABS_Y) begin
      cross_q <= (ea_idx[15:8] != ram_rdata);
    end
    if (cmd_i.read_capture) begin
      rd_res_q <= ram_rdata;
    end
    if (cmd_i.finish) begin
      out_q <= out_d;
    end
  end

  assign status_o.rdata    = ram_rdata;
  assign status_o.clr_done = (clr_q == '1);
  assign status_o.out_free = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_q;

endmodule

`default_nettype wire

// ===== design/aljcpu_ctrl.sv =====
// Controller: sequences memory clearing, requests and instruction steps.
`default_nettype none

module aljcpu_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_tvalid_i,
  input  wire logic [1:0]             s_tuser_i,
  output logic                        s_tready_o,
  input  wire aljcpu_pkg::dp_status_t status_i,
  output aljcpu_pkg::dp_cmd_t         cmd_o
);
  import aljcpu_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_RD_ISSUE,
    ST_RD_DATA,
    ST_RESTART,
    ST_FETCH,
    ST_DECODE,
    ST_BYTE1,
    ST_BYTE2,
    ST_PTR_LO,
    ST_PTR_HI,
    ST_PUSH_LO,
    ST_LOAD,
    ST_FINISH
  } state_e;

  state_e   state_q, state_d;
  op_kind_e kind_q, kind_d, dec_kind;
  logic     ready_q;

  assign dec_kind = op_kind_f(status_i.rdata);

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cmd_o   = '{default: '0, kind: OPK_ILL, mem_op: MEM_NONE};
    case (state_q)
      ST_CLEAR: begin
        cmd_o.mem_op = MEM_CLEAR;
        if (status_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid_i && ready_q) begin
          cmd_o.accept = 1'b1;
          case (req_type_e'(s_tuser_i))
            REQ_WRITE:   state_d = ST_WRITE;
            REQ_READ:    state_d = ST_RD_ISSUE;
            REQ_RESTART: state_d = ST_RESTART;
            REQ_EXEC:    state_d = ST_FETCH;
            default:     state_d = ST_FETCH;
          endcase
        end
      end
      ST_WRITE: begin
        cmd_o.mem_op = MEM_REQ_WR;
        state_d      = ST_FINISH;
      end
      ST_RD_ISSUE: begin
        cmd_o.mem_op = MEM_REQ_RD;
        state_d      = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        cmd_o.read_capture = 1'b1;
        state_d            = ST_FINISH;
      end
      ST_RESTART: begin
        cmd_o.restart = 1'b1;
        state_d       = ST_FINISH;
      end
      ST_FETCH: begin
        cmd_o.mem_op = MEM_FETCH;
        state_d      = ST_DECODE;
      end
      ST_DECODE: begin
        cmd_o.set_op = 1'b1;
        cmd_o.kind   = dec_kind;
        kind_d       = dec_kind;
        if (dec_kind == OPK_ILL) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.mem_op = MEM_FETCH;
          state_d      = ST_BYTE1;
        end
      end
      ST_BYTE1: begin
        case (kind_q)
          OPK_IMM: begin
            cmd_o.load_acc = 1'b1;
            state_d        = ST_FINISH;
          end
          OPK_ZP: begin
            cmd_o.mem_op = MEM_ZP;
            state_d      = ST_LOAD;
          end
          OPK_ZPX: begin
            cmd_o.mem_op = MEM_ZP_X;
            state_d      = ST_LOAD;
          end
          OPK_INDX: begin
            cmd_o.mem_op = MEM_ZP_X;
            state_d      = ST_PTR_LO;
          end
          OPK_INDY: begin
            cmd_o.mem_op = MEM_ZP;
            state_d      = ST_PTR_LO;
          end
          OPK_ABS, OPK_ABSX, OPK_ABSY, OPK_JSR: begin
            cmd_o.lo_load = 1'b1;
            cmd_o.mem_op  = MEM_FETCH;
            state_d       = ST_BYTE2;
          end
          default: state_d = ST_FINISH;
        endcase
      end
      ST_BYTE2: begin
        case (kind_q)
          OPK_ABS: begin
            cmd_o.mem_op = MEM_ABS;
            state_d      = ST_LOAD;
          end
          OPK_ABSX: begin
            cmd_o.mem_op = MEM_ABS_X;
            state_d      = ST_LOAD;
          end
          OPK_ABSY: begin
            cmd_o.mem_op = MEM_ABS_Y;
            state_d      = ST_LOAD;
          end
          OPK_JSR: begin
            // high byte of the return address goes first
            cmd_o.mem_op = MEM_PUSH_HI;
            state_d      = ST_PUSH_LO;
          end
          default: state_d = ST_FINISH;
        endcase
      end
      ST_PTR_LO: begin
        cmd_o.mem_op  = MEM_ZP_NEXT;
        cmd_o.lo_load = 1'b1;
        state_d       = ST_PTR_HI;
      end
      ST_PTR_HI: begin
        cmd_o.mem_op = (kind_q == OPK_INDY) ? MEM_ABS_Y : MEM_ABS;
        state_d      = ST_LOAD;
      end
      ST_PUSH_LO: begin
        cmd_o.mem_op = MEM_PUSH_LO;
        state_d      = ST_FINISH;
      end
      ST_LOAD: begin
        cmd_o.load_acc = 1'b1;
        state_d        = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      kind_q  <= OPK_ILL;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      ready_q <= (state_d == ST_IDLE);
    end
  end

  assign s_tready_o = ready_q;

endmodule

`default_nettype wire

// ===== design/aljcpu_checker.sv =====
// Port-level checker of the CPU step unit and its bind.
`default_nettype none

`include "accumulator_load_jsr_cpu_step_unit_defines.svh"

module aljcpu_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                cfg_valid_i,
  input wire logic                                cfg_ready_o,
  input wire logic [1:0]                          cfg_index_i,
  input wire logic [15:0]                         cfg_data_i,
  input wire logic                                s_axis_tvalid,
  input wire logic                                s_axis_tready,
  input wire logic [aljcpu_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input wire logic [1:0]                          s_axis_tuser,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [aljcpu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import aljcpu_pkg::*;

  out_item_t out_w;
  logic      unused_w;

  assign out_w    = out_item_t'(m_axis_tdata);
  assign unused_w = ^{cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i,
                      s_axis_tdata, s_axis_tuser};

  `ALJCPU_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result item changed while stalled")

  // one item at a time: input ready drops after an accept until the item is done
  `ALJCPU_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after an accept")

  `ALJCPU_ASSERT_IMP(a_illegal_cycles, m_axis_tvalid && out_w.illegal_opcode, out_w.cycles_used == 3'd1 && out_w.read_data == 8'h00, "illegal opcode result with wrong cycle count")

  `ALJCPU_ASSERT_IMP(a_read_no_cycles, m_axis_tvalid && (out_w.read_data != 8'h00 || unused_w !== unused_w), out_w.cycles_used == 3'd0 && !out_w.illegal_opcode, "read result reports instruction cycles")

  `ALJCPU_ASSERT_IMP(a_cycles_range, m_axis_tvalid, out_w.cycles_used != 3'd7 && out_w.pad == 2'b00, "result cycle count out of range")

endmodule

bind accumulator_load_jsr_cpu_step_unit aljcpu_checker u_checker (.*);

`default_nettype wire
